### hdl/rua_pkg.sv
`timescale 1ns / 1ps

package rua_pkg;

    localparam int unsigned TDATA_IN_W  = 64;
    localparam int unsigned TUSER_IN_W  = 3;
    localparam int unsigned TDATA_OUT_W = 8;

    localparam logic [23:0] DEFAULT_TIMEOUT_MS = 24'd100000;

    typedef enum logic [2:0] {
        CMD_TICK       = 3'd0,
        CMD_START_ACK  = 3'd1,
        CMD_START_N    = 3'd2,
        CMD_ACK        = 3'd3,
        CMD_INTERRUPT  = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        RESP_ACTIVE    = 3'd0,
        RESP_ACK_OK    = 3'd1,
        RESP_ACK_ERR   = 3'd2,
        RESP_TIMEOUT   = 3'd3,
        RESP_SENT_DONE = 3'd4,
        RESP_INTERRUPT = 3'd5
    } t_resp;

    localparam logic [1:0] ACK_NONE = 2'd0;
    localparam logic [1:0] ACK_OK   = 2'd1;

    typedef struct packed {
        logic [7:0]         backoff_ms;
        logic [1:0]         ack_status;
        logic [15:0]        sequence_req;
        logic [23:0]        timeout_ms;
        logic signed [8:0]  send_count;
        logic [2:0]         command;
    } t_in_item;

    typedef struct packed {
        logic       busy_res;
        logic [2:0] response_code;
        logic       done_res;
        logic       send_now;
    } t_out_item;

endpackage

### hdl/rua_in_stage.sv
`timescale 1ns / 1ps

module rua_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rua_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_take,
    output rua_pkg::t_in_item o_item
);

    logic              r_valid;
    rua_pkg::t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

### hdl/rua_core.sv
`timescale 1ns / 1ps

module rua_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  rua_pkg::t_in_item  i_item,
    output rua_pkg::t_out_item o_result
);

    logic [31:0]        r_now_ms,       n_now_ms;
    logic [31:0]        r_deadline_ms,  n_deadline_ms;
    logic [31:0]        r_last_send_ms, n_last_send_ms;
    logic [15:0]        r_sends_done,   n_sends_done;
    logic signed [8:0]  r_retry_limit,  n_retry_limit;
    logic               r_until_ack,    n_until_ack;
    logic               r_busy,         n_busy;
    logic [1:0]         r_stored_ack,   n_stored_ack;
    logic [15:0]        r_op_sequence,  n_op_sequence;
    rua_pkg::t_resp     r_last_code,    n_last_code;

    logic [31:0] now_inc;
    logic        timed_out;
    logic        limit_nonneg;
    logic [15:0] limit_u;
    logic        over_limit;
    logic        reached_limit;
    logic [32:0] due_ms;
    logic        backoff_done;
    logic [23:0] tmo_eff;
    rua_pkg::t_resp stop_code;
    logic        stop;

    assign now_inc       = r_now_ms + 32'd1;
    assign timed_out     = now_inc > r_deadline_ms;
    assign limit_nonneg  = !r_retry_limit[8];
    assign limit_u       = {8'd0, r_retry_limit[7:0]};
    assign over_limit    = limit_nonneg && (r_sends_done > limit_u);
    assign reached_limit = !limit_nonneg || (r_sends_done >= limit_u);
    assign due_ms        = {1'b0, r_last_send_ms} + {25'd0, i_item.backoff_ms};
    assign backoff_done  = {1'b0, now_inc} > due_ms;
    assign tmo_eff       = (i_item.timeout_ms == 24'd0) ? rua_pkg::DEFAULT_TIMEOUT_MS
                                                        : i_item.timeout_ms;

    // stop decision for an active tick
    always_comb begin
        stop      = 1'b1;
        stop_code = rua_pkg::RESP_TIMEOUT;
        if (r_until_ack) begin
            if (timed_out || over_limit) begin
                stop_code = rua_pkg::RESP_TIMEOUT;
            end else if (r_stored_ack != rua_pkg::ACK_NONE) begin
                stop_code = (r_stored_ack == rua_pkg::ACK_OK) ? rua_pkg::RESP_ACK_OK
                                                              : rua_pkg::RESP_ACK_ERR;
            end else begin
                stop = 1'b0;
            end
        end else begin
            if (timed_out) begin
                stop_code = rua_pkg::RESP_TIMEOUT;
            end else if (reached_limit) begin
                stop_code = rua_pkg::RESP_SENT_DONE;
            end else begin
                stop = 1'b0;
            end
        end
    end

    always_comb begin
        n_now_ms       = r_now_ms;
        n_deadline_ms  = r_deadline_ms;
        n_last_send_ms = r_last_send_ms;
        n_sends_done   = r_sends_done;
        n_retry_limit  = r_retry_limit;
        n_until_ack    = r_until_ack;
        n_busy         = r_busy;
        n_stored_ack   = r_stored_ack;
        n_op_sequence  = r_op_sequence;
        n_last_code    = r_last_code;
        o_result.send_now      = 1'b0;
        o_result.done_res      = 1'b0;
        o_result.response_code = r_last_code;

        unique case (rua_pkg::t_cmd'(i_item.command))
            rua_pkg::CMD_TICK: begin
                n_now_ms = now_inc;
                if (r_busy) begin
                    if (stop) begin
                        n_busy                 = 1'b0;
                        n_last_code            = stop_code;
                        o_result.done_res      = 1'b1;
                        o_result.response_code = stop_code;
                    end else if (backoff_done) begin
                        if (r_sends_done != 16'hFFFF) begin
                            n_sends_done = r_sends_done + 16'd1;
                        end
                        n_last_send_ms    = now_inc;
                        o_result.send_now = 1'b1;
                    end
                end
            end
            rua_pkg::CMD_START_ACK,
            rua_pkg::CMD_START_N: begin
                n_deadline_ms  = r_now_ms + {8'd0, tmo_eff};
                n_last_send_ms = 32'd0;
                n_sends_done   = 16'd0;
                n_stored_ack   = rua_pkg::ACK_NONE;
                n_retry_limit  = i_item.send_count;
                n_until_ack    = (i_item.command == rua_pkg::CMD_START_ACK);
                n_op_sequence  = i_item.sequence_req;
                n_busy         = 1'b1;
                n_last_code    = rua_pkg::RESP_ACTIVE;
                o_result.response_code = rua_pkg::RESP_ACTIVE;
            end
            rua_pkg::CMD_ACK: begin
                if (r_busy && r_stored_ack == rua_pkg::ACK_NONE
                    && r_op_sequence != 16'd0 && i_item.sequence_req == r_op_sequence) begin
                    n_stored_ack = i_item.ack_status;
                end
            end
            rua_pkg::CMD_INTERRUPT: begin
                if (r_busy) begin
                    n_busy                 = 1'b0;
                    n_last_code            = rua_pkg::RESP_INTERRUPT;
                    o_result.done_res      = 1'b1;
                    o_result.response_code = rua_pkg::RESP_INTERRUPT;
                end
            end
            default: begin
            end
        endcase

        o_result.busy_res = n_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now_ms       <= '0;
            r_deadline_ms  <= '0;
            r_last_send_ms <= '0;
            r_sends_done   <= '0;
            r_retry_limit  <= '0;
            r_until_ack    <= 1'b0;
            r_busy         <= 1'b0;
            r_stored_ack   <= rua_pkg::ACK_NONE;
            r_op_sequence  <= '0;
            r_last_code    <= rua_pkg::RESP_ACTIVE;
        end else if (i_fire) begin
            r_now_ms       <= n_now_ms;
            r_deadline_ms  <= n_deadline_ms;
            r_last_send_ms <= n_last_send_ms;
            r_sends_done   <= n_sends_done;
            r_retry_limit  <= n_retry_limit;
            r_until_ack    <= n_until_ack;
            r_busy         <= n_busy;
            r_stored_ack   <= n_stored_ack;
            r_op_sequence  <= n_op_sequence;
            r_last_code    <= n_last_code;
        end
    end

    a_done_clears_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_result.done_res |=> !r_busy)
        else $error("op still active after done");

    a_send_stamps_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_result.send_now |=> r_last_send_ms == r_now_ms && r_busy)
        else $error("send did not record send time");

    a_idle_holds_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_now_ms) && $stable(r_busy))
        else $error("state moved without an item");

    a_ack_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_stored_ack != rua_pkg::ACK_NONE
        && i_item.command == rua_pkg::CMD_ACK |=> $stable(r_stored_ack))
        else $error("stored ack overwritten");

endmodule

### hdl/rua_out_skid.sv
`timescale 1ns / 1ps

module rua_out_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_ready,
    input  rua_pkg::t_out_item i_result,
    output logic               o_valid,
    input  logic               i_pop_ready,
    output rua_pkg::t_out_item o_result
);

    logic               r_main_valid;
    logic               r_skid_valid;
    rua_pkg::t_out_item r_main;
    rua_pkg::t_out_item r_skid;
    logic               pop;
    logic               main_free;

    assign o_ready   = !r_skid_valid;
    assign o_valid   = r_main_valid;
    assign o_result  = r_main;
    assign pop       = r_main_valid && i_pop_ready;
    assign main_free = !r_main_valid || pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (pop) begin
                    r_main_valid <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (i_push) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= !main_free;
            end else if (pop) begin
                r_main_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (main_free) begin
                r_main <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end
    end

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry without main entry");

    a_stall_keeps_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !i_pop_ready |=> r_skid_valid && $stable(r_skid))
        else $error("skid entry lost during stall");

    a_push_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && o_ready |=> r_main_valid)
        else $error("pushed result not held");

endmodule

### hdl/retransmit_until_ack_controller.sv
`timescale 1ns / 1ps

// Retransmit controller: until-ack and send-n-times modes over a ms tick.
// Input channel (s_axis): one command item per handshake. tuser carries the
// command (tick, start until ack, start n times, ack, interrupt); tdata
// carries the operands. Output channel (m_axis): exactly one result item per
// input item, in order, giving send_now, done, response code and busy.
// Path: an accepted item waits in the input register, then the decision logic
// writes its result into the output register.
// Throughput: one item per cycle unless the output stalls; decision logic and all
// state update as an item is taken, so it sees the state left by the one before.
// Reset: all timers, counters and the operation state clear to zero, no
// operation active, last response code "active".
// When the receiver stalls, the output register, one skid entry and the
// input register fill up; after that s_axis_tready drops until results are
// taken. Nothing is dropped or repeated.

module retransmit_until_ack_controller (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [8:0] send_count, [32:9] timeout_ms, [48:33] sequence_req,
    // [50:49] ack_status, [58:51] backoff_ms, [63:59] zero
    input  logic [rua_pkg::TDATA_IN_W-1:0]     i_s_axis_tdata,
    // [2:0] command
    input  logic [rua_pkg::TUSER_IN_W-1:0]     i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [0] send_now, [1] done_res, [4:2] response_code, [5] busy_res, [7:6] zero
    output logic [rua_pkg::TDATA_OUT_W-1:0]    o_m_axis_tdata
);

    rua_pkg::t_in_item  in_item;
    rua_pkg::t_in_item  stage_item;
    rua_pkg::t_out_item core_result;
    rua_pkg::t_out_item out_result;
    logic               stage_valid;
    logic               out_ready;
    logic               fire;

    assign in_item.command      = i_s_axis_tuser;
    assign in_item.send_count   = i_s_axis_tdata[8:0];
    assign in_item.timeout_ms   = i_s_axis_tdata[32:9];
    assign in_item.sequence_req = i_s_axis_tdata[48:33];
    assign in_item.ack_status   = i_s_axis_tdata[50:49];
    assign in_item.backoff_ms   = i_s_axis_tdata[58:51];

    assign fire = stage_valid && out_ready;

    rua_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (in_item),
        .o_valid (stage_valid),
        .i_take  (fire),
        .o_item  (stage_item)
    );

    rua_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (stage_item),
        .o_result (core_result)
    );

    rua_out_skid u_out_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (fire),
        .o_ready     (out_ready),
        .i_result    (core_result),
        .o_valid     (o_m_axis_tvalid),
        .i_pop_ready (i_m_axis_tready),
        .o_result    (out_result)
    );

    assign o_m_axis_tdata = {2'b00, out_result};

endmodule

### dv/retransmit_until_ack_controller_tb.sv
`timescale 1ns / 1ps

module retransmit_until_ack_controller_tb;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int RANDOM_ITEMS = 1300;
    localparam logic [2:0] CMD_UNDEF_LO = 3'd5;
    localparam logic [2:0] CMD_UNDEF_HI = 3'd7;

    class arq_scoreboard;
        rua_pkg::t_out_item exp_q[$];
        int n_err;
        bit [31:0] now_ms;
        bit [31:0] deadline_ms;
        bit [31:0] last_tx_ms;
        bit [15:0] tx_count;
        bit signed [8:0] retry_limit;
        bit until_ack;
        bit busy;
        bit [1:0] ack_seen;
        bit [15:0] op_seq;
        bit [2:0] last_code;

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            n_err++;
        endtask

        function void note_item(rua_pkg::t_in_item it);
            rua_pkg::t_out_item e;
            bit stopping;
            bit [2:0] stop_code;
            bit [23:0] tmo;
            int lim;
            int sent;
            e = '0;
            stopping = 1'b0;
            stop_code = rua_pkg::RESP_ACTIVE;
            lim = retry_limit;
            sent = tx_count;
            unique case (it.command)
                rua_pkg::CMD_TICK: begin
                    now_ms++;
                    if (busy) begin
                        if (now_ms > deadline_ms) begin
                            stopping = 1'b1;
                            stop_code = rua_pkg::RESP_TIMEOUT;
                        end else if (until_ack && lim >= 0 && sent > lim) begin
                            stopping = 1'b1;
                            stop_code = rua_pkg::RESP_TIMEOUT;
                        end else if (until_ack && ack_seen != rua_pkg::ACK_NONE) begin
                            stopping = 1'b1;
                            stop_code = (ack_seen == rua_pkg::ACK_OK) ?
                                rua_pkg::RESP_ACK_OK : rua_pkg::RESP_ACK_ERR;
                        end else if (!until_ack && sent >= lim) begin
                            stopping = 1'b1;
                            stop_code = rua_pkg::RESP_SENT_DONE;
                        end else if ({1'b0, now_ms} >
                                {1'b0, last_tx_ms} + {25'd0, it.backoff_ms}) begin
                            if (tx_count != 16'hFFFF) tx_count++;
                            last_tx_ms = now_ms;
                            e.send_now = 1'b1;
                        end
                    end
                end
                rua_pkg::CMD_START_ACK, rua_pkg::CMD_START_N: begin
                    tmo = it.timeout_ms;
                    if (tmo == 24'd0) tmo = rua_pkg::DEFAULT_TIMEOUT_MS;
                    deadline_ms = now_ms + {8'd0, tmo};
                    last_tx_ms = '0;
                    tx_count = '0;
                    ack_seen = rua_pkg::ACK_NONE;
                    retry_limit = it.send_count;
                    until_ack = (it.command == rua_pkg::CMD_START_ACK);
                    op_seq = it.sequence_req;
                    busy = 1'b1;
                    last_code = rua_pkg::RESP_ACTIVE;
                end
                rua_pkg::CMD_ACK: begin
                    if (op_seq != 16'd0 && busy && ack_seen == rua_pkg::ACK_NONE &&
                            it.sequence_req == op_seq) ack_seen = it.ack_status;
                end
                rua_pkg::CMD_INTERRUPT: begin
                    if (busy) begin
                        stopping = 1'b1;
                        stop_code = rua_pkg::RESP_INTERRUPT;
                    end
                end
                default: ;
            endcase
            if (stopping) begin
                busy = 1'b0;
                last_code = stop_code;
                e.done_res = 1'b1;
            end
            e.response_code = last_code;
            e.busy_res = busy;
            exp_q.push_back(e);
        endfunction

        task check(logic [rua_pkg::TDATA_OUT_W-1:0] d);
            rua_pkg::t_out_item got;
            rua_pkg::t_out_item e;
            got = d[5:0];
            if (exp_q.size() == 0) begin
                report($sformatf("result %h with nothing expected", d));
                return;
            end
            e = exp_q.pop_front();
            if (got.send_now !== e.send_now)
                report($sformatf("send_now %b exp %b", got.send_now, e.send_now));
            if (got.done_res !== e.done_res)
                report($sformatf("done_res %b exp %b", got.done_res, e.done_res));
            if (got.response_code !== e.response_code)
                report($sformatf("response_code %0d exp %0d", got.response_code,
                    e.response_code));
            if (got.busy_res !== e.busy_res)
                report($sformatf("busy_res %b exp %b", got.busy_res, e.busy_res));
            if (d[7:6] !== 2'b00)
                report($sformatf("padding bits %b", d[7:6]));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [rua_pkg::TDATA_IN_W-1:0] s_tdata = '0;
    logic [rua_pkg::TUSER_IN_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [rua_pkg::TDATA_OUT_W-1:0] m_tdata;

    arq_scoreboard sb = new();
    bit idle_in = 1'b0;
    bit idle_out = 1'b0;
    int rx_hold = 0;
    int n_items = 0;
    int unsigned cycles = 0;

    retransmit_until_ack_controller uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) sb.check(m_tdata);
    end

    // result side: random stalls, plus a long hold-off when requested
    initial begin
        int stall;
        while (!rst_n) @(posedge clk);
        forever begin
            stall = rx_hold + (idle_out ? $urandom_range(0, 17) : 0);
            rx_hold = 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    function automatic rua_pkg::t_in_item mk(logic [2:0] cmd, logic signed [8:0] cnt,
            logic [23:0] tmo, logic [15:0] seq, logic [1:0] ack, logic [7:0] bo);
        rua_pkg::t_in_item it;
        it.command = cmd;
        it.send_count = cnt;
        it.timeout_ms = tmo;
        it.sequence_req = seq;
        it.ack_status = ack;
        it.backoff_ms = bo;
        return it;
    endfunction

    function automatic rua_pkg::t_in_item rand_item();
        return mk(rua_pkg::CMD_TICK, 9'($urandom), 24'($urandom), 16'($urandom),
            2'($urandom), 8'($urandom));
    endfunction

    task automatic send_item(rua_pkg::t_in_item it);
        int gap;
        gap = idle_in ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, it.backoff_ms, it.ack_status, it.sequence_req, it.timeout_ms,
            it.send_count};
        s_tuser <= it.command;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_item(it);
        if (it.command <= rua_pkg::CMD_INTERRUPT) n_items++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.exp_q.size() != 0);
    endtask

    // one operation: a start, then mostly ticks with acks, interrupts and noise mixed in
    task automatic random_op();
        rua_pkg::t_in_item it;
        int r;
        int len;
        bit [15:0] op_seq;
        it = rand_item();
        it.command = $urandom_range(0, 1) ? rua_pkg::CMD_START_ACK : rua_pkg::CMD_START_N;
        r = $urandom_range(0, 99);
        if (r < 60) it.send_count = 9'($urandom_range(0, 3));
        else if (r < 75) it.send_count = 9'h1FF;
        else if (r < 92) it.send_count = 9'($urandom_range(4, 255));
        r = $urandom_range(0, 99);
        if (r < 70) it.timeout_ms = 24'($urandom_range(1, 300));
        else if (r < 80) it.timeout_ms = '0;
        else if (r < 90) it.timeout_ms = 24'($urandom_range(301, 2000));
        if ($urandom_range(0, 9) == 0) it.sequence_req = '0;
        op_seq = it.sequence_req;
        send_item(it);
        len = $urandom_range(20, 140);
        repeat (len) begin
            it = rand_item();
            r = $urandom_range(0, 99);
            if (r < 82) begin
                it.command = rua_pkg::CMD_TICK;
                r = $urandom_range(0, 99);
                if (r < 70) it.backoff_ms = 8'($urandom_range(20, 40));
                else if (r < 95) it.backoff_ms = 8'($urandom_range(20, 199));
            end else if (r < 92) begin
                it.command = rua_pkg::CMD_ACK;
                if ($urandom_range(0, 3) != 0) it.sequence_req = op_seq;
            end else if (r < 95) begin
                it.command = rua_pkg::CMD_INTERRUPT;
            end else if (r < 97) begin
                it.command = 3'($urandom_range(CMD_UNDEF_LO, CMD_UNDEF_HI));
            end else begin
                it.command = $urandom_range(0, 1) ? rua_pkg::CMD_START_ACK
                                                  : rua_pkg::CMD_START_N;
            end
            send_item(it);
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle: ack, interrupt and undefined commands do nothing; ticks advance time
        send_item(mk(rua_pkg::CMD_TICK, 9'd0, 24'd0, 16'd0, rua_pkg::ACK_NONE, 8'd0));
        send_item(mk(rua_pkg::CMD_ACK, 9'd0, 24'd0, 16'd0, rua_pkg::ACK_OK, 8'd0));
        send_item(mk(rua_pkg::CMD_INTERRUPT, '1, '1, '1, '1, '1));
        send_item(mk(CMD_UNDEF_LO, '1, '1, '1, '1, '1));
        send_item(mk(CMD_UNDEF_HI, 9'd0, 24'd0, 16'd0, rua_pkg::ACK_NONE, 8'd0));
        // sequence zero never takes an ack; zero timeout uses the default
        send_item(mk(rua_pkg::CMD_START_ACK, 9'h1FF, 24'd0, 16'd0, rua_pkg::ACK_NONE,
            8'd0));
        send_item(mk(rua_pkg::CMD_ACK, 9'd0, 24'd0, 16'd0, rua_pkg::ACK_OK, 8'd0));
        send_item(mk(rua_pkg::CMD_TICK, 9'd0, 24'd0, 16'd0, rua_pkg::ACK_NONE, 8'd255));
        // restart over a running op
        send_item(mk(rua_pkg::CMD_START_N, 9'd255, 24'hFFFFFF, 16'hFFFF,
            rua_pkg::ACK_NONE, 8'd0));
        send_item(mk(rua_pkg::CMD_ACK, 9'd0, 24'd0, 16'hFFFF, 2'd3, 8'd0));
        send_item(mk(rua_pkg::CMD_TICK, 9'd0, 24'd0, 16'd0, rua_pkg::ACK_NONE, 8'd0));
        // zero and negative limits in send-n mode
        send_item(mk(rua_pkg::CMD_START_N, 9'd0, 24'd1, 16'h1234, rua_pkg::ACK_NONE,
            8'd0));
        send_item(mk(rua_pkg::CMD_TICK, 9'd0, 24'd0, 16'd0, rua_pkg::ACK_NONE, 8'd0));
        send_item(mk(rua_pkg::CMD_START_N, 9'h100, 24'd7, 16'h0001, rua_pkg::ACK_NONE,
            8'd0));
        send_item(mk(rua_pkg::CMD_TICK, 9'd0, 24'd0, 16'd0, rua_pkg::ACK_NONE, 8'd0));
        // retry limit passed in until-ack mode
        send_item(mk(rua_pkg::CMD_START_ACK, 9'd0, 24'd5, 16'h00A5, rua_pkg::ACK_NONE,
            8'd0));
        send_item(mk(rua_pkg::CMD_TICK, 9'd0, 24'd0, 16'd0, rua_pkg::ACK_NONE, 8'd0));
        send_item(mk(rua_pkg::CMD_TICK, 9'd0, 24'd0, 16'd0, rua_pkg::ACK_NONE, 8'd0));
        // ack filtering: wrong sequence, no-response status, then first error sticks
        send_item(mk(rua_pkg::CMD_START_ACK, 9'd5, 24'd20, 16'h0007, rua_pkg::ACK_NONE,
            8'd0));
        send_item(mk(rua_pkg::CMD_ACK, 9'd0, 24'd0, 16'h0008, rua_pkg::ACK_OK, 8'd0));
        send_item(mk(rua_pkg::CMD_ACK, 9'd0, 24'd0, 16'h0007, rua_pkg::ACK_NONE, 8'd0));
        send_item(mk(rua_pkg::CMD_ACK, 9'd0, 24'd0, 16'h0007, 2'd2, 8'd0));
        send_item(mk(rua_pkg::CMD_ACK, 9'd0, 24'd0, 16'h0007, rua_pkg::ACK_OK, 8'd0));
        send_item(mk(rua_pkg::CMD_TICK, 9'd0, 24'd0, 16'd0, rua_pkg::ACK_NONE, 8'd0));
        send_item(mk(rua_pkg::CMD_START_N, 9'd3, 24'd50, 16'h0001, rua_pkg::ACK_NONE,
            8'd0));
        send_item(mk(rua_pkg::CMD_INTERRUPT, 9'd0, 24'd0, 16'd0, rua_pkg::ACK_NONE, 8'd0));
        send_item(mk(rua_pkg::CMD_INTERRUPT, 9'd0, 24'd0, 16'd0, rua_pkg::ACK_NONE, 8'd0));

        // long receiver hold-off with the sender pushing back to back
        n_items = 0;
        idle_in = 1'b0;
        idle_out = 1'b0;
        rx_hold = 80;
        random_op();
        drain();

        while (n_items < RANDOM_ITEMS) begin
            idle_in = $urandom_range(0, 3) != 0;
            idle_out = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 7) == 0) drain();
            random_op();
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.n_err == 0 && sb.exp_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sim.f
hdl/rua_pkg.sv
hdl/rua_in_stage.sv
hdl/rua_core.sv
hdl/rua_out_skid.sv
hdl/retransmit_until_ack_controller.sv
dv/retransmit_until_ack_controller_tb.sv
